>>> src/tsolve_pkg.sv
// Shared types, constants and saturating helpers of the tridiagonal solver.
package tsolve_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;

    localparam logic REG_PERIODIC = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FMUL_S,
        ST_FMUL_R,
        ST_FMUL_C,
        ST_FN2,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_BREAD,
        ST_BMUL,
        ST_BSUM,
        ST_PFIX,
        ST_PREAD,
        ST_PMUL_R,
        ST_PMUL_C,
        ST_PWRITE,
        ST_PW_M1,
        ST_PW_M2,
        ST_PW_M3,
        ST_PW_M4,
        ST_PW_N
    } state_t;

    typedef struct packed {
        logic done;
        logic dzero;
    } div_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -64'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(64'(a) + 64'(b));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32(64'(a) - 64'(b));
    endfunction

endpackage

>>> src/tsolve_if.sv
// Row and result channel interfaces of the tridiagonal solver.
interface tsolve_row_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sub_coef;
    logic signed [31:0] diag_coef;
    logic signed [31:0] super_coef;
    logic signed [31:0] rhs_value;
    logic               last_row;

    modport source (output valid, sub_coef, diag_coef, super_coef, rhs_value, last_row,
                    input ready);
    modport sink (input valid, sub_coef, diag_coef, super_coef, rhs_value, last_row,
                  output ready);
endinterface

interface tsolve_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic               last_result;
    logic               singular;

    modport source (output valid, solution, row_index, last_result, singular,
                    input ready);
    modport sink (input valid, solution, row_index, last_result, singular,
                  output ready);
endinterface

>>> src/tsolve_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsolve_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/tsolve_div.sv
// Three-lane bit-serial fixed-point divider sharing one divisor.
module tsolve_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [31:0]       num [3],
    input  logic signed [31:0]       den,
    output logic signed [31:0]       quo [3],
    output tsolve_pkg::div_status_t  status
);

    localparam int QW = 32 + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);
    localparam logic [QW-1:0] LIM_POS = QW'(64'h7fffffff);
    localparam logic [QW-1:0] LIM_NEG = QW'(64'h80000000);

    logic                busy_reg;
    logic [CW-1:0]       cnt_reg;
    logic [31:0]         dv_reg;
    logic                neg_reg [3];
    logic [31:0]         rem_reg [3];
    logic [QW-1:0]       sh_reg [3];
    logic signed [31:0]  quo_reg [3];
    logic                done_reg;
    logic                dz_reg;

    logic [32:0]         trial [3];
    logic                qbit [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            trial[k] = {rem_reg[k], sh_reg[k][QW-1]};
            qbit[k]  = trial[k] >= {1'b0, dv_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == 32'sd0)
                begin
                    done_reg <= 1'b1;
                    dz_reg   <= 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        quo_reg[k] <= 32'sd0;
                    end
                end
                else
                begin
                    busy_reg <= 1'b1;
                    dz_reg   <= 1'b0;
                    cnt_reg  <= CW'(QW);
                    dv_reg   <= den[31] ? 32'(-den) : 32'(den);
                    for (int k = 0; k < 3; k++)
                    begin
                        neg_reg[k] <= num[k][31] ^ den[31];
                        rem_reg[k] <= '0;
                        sh_reg[k]  <= QW'(num[k][31] ? 32'(-num[k]) : 32'(num[k]))
                                      << FRAC_BITS;
                    end
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        rem_reg[k] <= qbit[k] ? 32'(trial[k] - {1'b0, dv_reg})
                                              : trial[k][31:0];
                        sh_reg[k]  <= {sh_reg[k][QW-2:0], qbit[k]};
                    end
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (neg_reg[k])
                            quo_reg[k] <= (sh_reg[k] > LIM_NEG) ? 32'sh80000000
                                                                : -$signed(sh_reg[k][31:0]);
                        else
                            quo_reg[k] <= (sh_reg[k] > LIM_POS) ? 32'sh7fffffff
                                                                : $signed(sh_reg[k][31:0]);
                    end
                end
            end
        end
    end

    assign quo          = quo_reg;
    assign status.done  = done_reg;
    assign status.dzero = dz_reg;

endmodule

>>> src/tridiagonal_system_solver_top.sv
// Tridiagonal solver: Thomas sweep with memories for the modified terms.
// A row without the last mark passes the forward multiply states and the bit-serial divider.
// The closing row is solved the same way, after a sweep over the earlier rows in cyclic mode;
// then its results leave one at a time, highest index first, while the output is taken.
// One row is worked at a time; the next row is accepted once the previous one is done.
// rst_n clears the state, the row counter, the zero-divisor flag, the mode and the output valid flag.
module tridiagonal_system_solver_top #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tsolve_row_if.sink    row,
    tsolve_res_if.source  res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int IW = tsolve_pkg::IDX_W;

    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [63:0] t;
        begin
            t = p + (64'sd1 <<< (FRAC_BITS - 1));
            return tsolve_pkg::sat32(t >>> FRAC_BITS);
        end
    endfunction

    tsolve_pkg::state_t state_reg, state_next;

    logic signed [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [AW-1:0]      r_reg, i_reg, idx_reg;
    logic               fwd_reg, per_reg, periodic_reg, zero_reg;
    logic signed [31:0] ps_reg, pr_reg, pc_reg;
    logic signed [31:0] den_reg, n1_reg, n2_reg, t_reg;
    logic signed [31:0] cur_r_reg, cur_c_reg, cn1_reg, rn1_reg;
    logic signed [31:0] s_i_reg, r_i_reg, c_i_reg;
    logic signed [31:0] x_reg, xn_reg;
    logic signed [63:0] prod_reg;

    logic               ov_reg, olast_reg, osing_reg;
    logic signed [31:0] osol_reg;
    logic [IW-1:0]      oidx_reg;

    logic signed [31:0] rnd;
    logic signed [31:0] mul_a, mul_b;
    logic               accept, last_eff, r0, out_free;
    logic               div_start;
    logic signed [31:0] dnum [3];
    logic signed [31:0] dquo [3];
    tsolve_pkg::div_status_t dstat;

    logic               we_s, we_r, we_c;
    logic [AW-1:0]      waddr;
    logic [31:0]        wd_s, wd_r, wd_c;
    logic [31:0]        rd_s_raw, rd_r_raw, rd_c_raw;
    logic signed [31:0] rd_s, rd_r, rd_c;

    assign rd_s = $signed(rd_s_raw);
    assign rd_r = $signed(rd_r_raw);
    assign rd_c = $signed(rd_c_raw);

    assign rnd      = qround(prod_reg);
    assign accept   = row.valid && row.ready;
    assign last_eff = row.last_row || (r_reg == AW'(MAX_ROWS - 1));
    assign r0       = (r_reg == '0);
    assign out_free = !ov_reg || res.ready;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tsolve_pkg::REG_PERIODIC) ? {31'b0, periodic_reg} : 32'b0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsolve_pkg::ST_IDLE:
                if (accept)
                    state_next = (last_eff && periodic_reg && !r0) ? tsolve_pkg::ST_PFIX
                                                                   : tsolve_pkg::ST_FMUL_S;
            tsolve_pkg::ST_FMUL_S:  state_next = tsolve_pkg::ST_FMUL_R;
            tsolve_pkg::ST_FMUL_R:  state_next = tsolve_pkg::ST_FMUL_C;
            tsolve_pkg::ST_FMUL_C:  state_next = tsolve_pkg::ST_FN2;
            tsolve_pkg::ST_FN2:     state_next = tsolve_pkg::ST_DIV_GO;
            tsolve_pkg::ST_DIV_GO:  state_next = tsolve_pkg::ST_DIV_WAIT;
            tsolve_pkg::ST_DIV_WAIT:
                if (dstat.done)
                    state_next = fwd_reg ? tsolve_pkg::ST_IDLE : tsolve_pkg::ST_EMIT;
            tsolve_pkg::ST_EMIT:
                if (out_free)
                    state_next = (idx_reg == '0) ? tsolve_pkg::ST_IDLE : tsolve_pkg::ST_BREAD;
            tsolve_pkg::ST_BREAD:   state_next = tsolve_pkg::ST_BMUL;
            tsolve_pkg::ST_BMUL:    state_next = tsolve_pkg::ST_BSUM;
            tsolve_pkg::ST_BSUM:    state_next = tsolve_pkg::ST_EMIT;
            tsolve_pkg::ST_PFIX:
                state_next = (r_reg >= AW'(2)) ? tsolve_pkg::ST_PREAD : tsolve_pkg::ST_PW_M1;
            tsolve_pkg::ST_PREAD:   state_next = tsolve_pkg::ST_PMUL_R;
            tsolve_pkg::ST_PMUL_R:  state_next = tsolve_pkg::ST_PMUL_C;
            tsolve_pkg::ST_PMUL_C:  state_next = tsolve_pkg::ST_PWRITE;
            tsolve_pkg::ST_PWRITE:
                state_next = (i_reg == '0) ? tsolve_pkg::ST_PW_M1 : tsolve_pkg::ST_PREAD;
            tsolve_pkg::ST_PW_M1:   state_next = tsolve_pkg::ST_PW_M2;
            tsolve_pkg::ST_PW_M2:   state_next = tsolve_pkg::ST_PW_M3;
            tsolve_pkg::ST_PW_M3:   state_next = tsolve_pkg::ST_PW_M4;
            tsolve_pkg::ST_PW_M4:   state_next = tsolve_pkg::ST_PW_N;
            tsolve_pkg::ST_PW_N:    state_next = tsolve_pkg::ST_DIV_GO;
            default:                state_next = tsolve_pkg::ST_IDLE;
        endcase
    end

    // control outputs: row ready, multiplier operands, memory ports, divider start
    always_comb
    begin
        row.ready = (state_reg == tsolve_pkg::ST_IDLE);
        div_start = 1'b0;
        mul_a     = 32'sd0;
        mul_b     = 32'sd0;
        we_s      = 1'b0;
        we_r      = 1'b0;
        we_c      = 1'b0;
        waddr     = r_reg;
        wd_s      = 32'(dquo[0]);
        wd_r      = 32'(dquo[1]);
        wd_c      = 32'(dquo[2]);
        case (state_reg)
            tsolve_pkg::ST_FMUL_S:
            begin
                mul_a = a_reg;
                mul_b = r0 ? 32'sd0 : ps_reg;
            end
            tsolve_pkg::ST_FMUL_R:
            begin
                mul_a = a_reg;
                mul_b = r0 ? 32'sd0 : pr_reg;
            end
            tsolve_pkg::ST_FMUL_C:
            begin
                mul_a = a_reg;
                mul_b = r0 ? 32'sd0 : pc_reg;
            end
            tsolve_pkg::ST_DIV_GO:
                div_start = 1'b1;
            tsolve_pkg::ST_DIV_WAIT:
            begin
                we_s = dstat.done && fwd_reg;
                we_r = dstat.done && fwd_reg;
                we_c = dstat.done && fwd_reg;
            end
            tsolve_pkg::ST_BMUL:
            begin
                mul_a = per_reg ? rd_c : rd_s;
                mul_b = per_reg ? xn_reg : x_reg;
            end
            tsolve_pkg::ST_PFIX:
            begin
                we_c  = 1'b1;
                waddr = r_reg - 1'b1;
                wd_c  = 32'(tsolve_pkg::qsub(pc_reg, ps_reg));
            end
            tsolve_pkg::ST_PMUL_R:
            begin
                mul_a = rd_s;
                mul_b = cur_r_reg;
            end
            tsolve_pkg::ST_PMUL_C:
            begin
                mul_a = s_i_reg;
                mul_b = cur_c_reg;
            end
            tsolve_pkg::ST_PWRITE:
            begin
                we_r  = 1'b1;
                we_c  = 1'b1;
                waddr = i_reg;
                wd_r  = 32'(cur_r_reg);
                wd_c  = 32'(tsolve_pkg::qsub(c_i_reg, rnd));
            end
            tsolve_pkg::ST_PW_M1:
            begin
                mul_a = c_reg;
                mul_b = cur_c_reg;
            end
            tsolve_pkg::ST_PW_M2:
            begin
                mul_a = a_reg;
                mul_b = cn1_reg;
            end
            tsolve_pkg::ST_PW_M3:
            begin
                mul_a = c_reg;
                mul_b = cur_r_reg;
            end
            tsolve_pkg::ST_PW_M4:
            begin
                mul_a = a_reg;
                mul_b = rn1_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tsolve_pkg::ST_IDLE;
            r_reg        <= '0;
            zero_reg     <= 1'b0;
            periodic_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && pready && paddr[2] == tsolve_pkg::REG_PERIODIC)
            begin
                periodic_reg <= pwdata[0];
            end
            if (state_reg == tsolve_pkg::ST_EMIT && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                tsolve_pkg::ST_DIV_WAIT:
                    if (dstat.done)
                    begin
                        zero_reg <= zero_reg | dstat.dzero;
                        if (fwd_reg)
                            r_reg <= r_reg + 1'b1;
                    end
                tsolve_pkg::ST_EMIT:
                    if (out_free)
                    begin
                        if (idx_reg == '0)
                        begin
                            r_reg    <= '0;
                            zero_reg <= 1'b0;
                        end
                    end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (state_reg)
            tsolve_pkg::ST_IDLE:
                if (accept)
                begin
                    a_reg   <= row.sub_coef;
                    b_reg   <= row.diag_coef;
                    c_reg   <= row.super_coef;
                    d_reg   <= row.rhs_value;
                    fwd_reg <= !last_eff;
                    per_reg <= periodic_reg;
                end
            tsolve_pkg::ST_FMUL_R:  den_reg <= tsolve_pkg::qsub(b_reg, rnd);
            tsolve_pkg::ST_FMUL_C:  n1_reg  <= tsolve_pkg::qsub(d_reg, rnd);
            tsolve_pkg::ST_FN2:
                n2_reg <= r0 ? tsolve_pkg::qsub(32'sd0, a_reg) : tsolve_pkg::qsub(32'sd0, rnd);
            tsolve_pkg::ST_DIV_WAIT:
                if (dstat.done)
                begin
                    ps_reg  <= dquo[0];
                    pr_reg  <= dquo[1];
                    pc_reg  <= dquo[2];
                    x_reg   <= dquo[1];
                    xn_reg  <= dquo[1];
                    idx_reg <= r_reg;
                end
            tsolve_pkg::ST_EMIT:
                if (out_free)
                begin
                    osol_reg  <= x_reg;
                    oidx_reg  <= IW'(idx_reg);
                    olast_reg <= (idx_reg == '0);
                    osing_reg <= zero_reg;
                    i_reg     <= idx_reg - 1'b1;
                end
            tsolve_pkg::ST_BMUL:    r_i_reg <= rd_r;
            tsolve_pkg::ST_BSUM:
            begin
                x_reg   <= per_reg ? tsolve_pkg::qadd(r_i_reg, rnd)
                                   : tsolve_pkg::qsub(r_i_reg, rnd);
                idx_reg <= i_reg;
            end
            tsolve_pkg::ST_PFIX:
            begin
                cur_c_reg <= tsolve_pkg::qsub(pc_reg, ps_reg);
                cn1_reg   <= tsolve_pkg::qsub(pc_reg, ps_reg);
                cur_r_reg <= pr_reg;
                rn1_reg   <= pr_reg;
                i_reg     <= r_reg - AW'(2);
            end
            tsolve_pkg::ST_PMUL_R:
            begin
                s_i_reg <= rd_s;
                r_i_reg <= rd_r;
                c_i_reg <= rd_c;
            end
            tsolve_pkg::ST_PMUL_C:  cur_r_reg <= tsolve_pkg::qsub(r_i_reg, rnd);
            tsolve_pkg::ST_PWRITE:
            begin
                cur_c_reg <= tsolve_pkg::qsub(c_i_reg, rnd);
                i_reg     <= i_reg - 1'b1;
            end
            tsolve_pkg::ST_PW_M2:   t_reg   <= tsolve_pkg::qadd(b_reg, rnd);
            tsolve_pkg::ST_PW_M3:   den_reg <= tsolve_pkg::qadd(t_reg, rnd);
            tsolve_pkg::ST_PW_M4:   t_reg   <= tsolve_pkg::qsub(d_reg, rnd);
            tsolve_pkg::ST_PW_N:    n1_reg  <= tsolve_pkg::qsub(t_reg, rnd);
            default:
            begin
            end
        endcase
    end

    assign dnum[0] = c_reg;
    assign dnum[1] = n1_reg;
    assign dnum[2] = n2_reg;

    tsolve_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (dnum),
        .den    (den_reg),
        .quo    (dquo),
        .status (dstat)
    );

    tsolve_ram #(.WIDTH(tsolve_pkg::DATA_W), .DEPTH(MAX_ROWS)) u_super_ram (
        .clk   (clk),
        .we    (we_s),
        .waddr (waddr),
        .wdata (wd_s),
        .raddr (i_reg),
        .rdata (rd_s_raw)
    );

    tsolve_ram #(.WIDTH(tsolve_pkg::DATA_W), .DEPTH(MAX_ROWS)) u_rhs_ram (
        .clk   (clk),
        .we    (we_r),
        .waddr (waddr),
        .wdata (wd_r),
        .raddr (i_reg),
        .rdata (rd_r_raw)
    );

    tsolve_ram #(.WIDTH(tsolve_pkg::DATA_W), .DEPTH(MAX_ROWS)) u_corr_ram (
        .clk   (clk),
        .we    (we_c),
        .waddr (waddr),
        .wdata (wd_c),
        .raddr (i_reg),
        .rdata (rd_c_raw)
    );

    assign res.valid       = ov_reg;
    assign res.solution    = osol_reg;
    assign res.row_index   = oidx_reg;
    assign res.last_result = olast_reg;
    assign res.singular    = osing_reg;

endmodule
